// File: src/mpq_pkg.sv
// Package for the max priority queue: item types, operation and status codes.
// No dependencies; every other file in src/ uses it.
package mpq_pkg;

	localparam int ValueW = 32;
	localparam int StatusW = 2;
	localparam int OccW = 5;

	// operation codes (kind field)
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status codes
	localparam logic [StatusW-1:0] ST_OK        = 2'd0;
	localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd2;

	typedef logic signed [ValueW-1:0] value_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   rem;
		value_t value;
	} cell_cmd_t;

endpackage

// File: src/mpq_req_if.sv
// Request channel of the priority queue: valid/ready plus the operation item.
// Depends on mpq_pkg.
interface mpq_req_if;
	logic                valid;
	logic                ready;
	logic                kind;
	mpq_pkg::value_t     value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

// File: src/mpq_rsp_if.sv
// Response channel of the priority queue: valid/ready plus the result item.
// Depends on mpq_pkg.
interface mpq_rsp_if;
	logic                              valid;
	logic                              ready;
	mpq_pkg::value_t                   result_value;
	logic [mpq_pkg::StatusW-1:0]       status;
	logic [mpq_pkg::OccW-1:0]          occupancy;

	modport source (output valid, output result_value, output status, output occupancy,
		input ready);
	modport sink   (input valid, input result_value, input status, input occupancy,
		output ready);
endinterface

// File: src/mpq_cell.sv
// One cell of the sorted chain: holds one value, trades with its neighbors.
// Depends on mpq_pkg.
module mpq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic               clk,
	input  mpq_pkg::cell_cmd_t cmd,
	input  logic [CW-1:0]      count,
	input  mpq_pkg::value_t    left_val,
	input  mpq_pkg::value_t    right_val,
	output mpq_pkg::value_t    val_q
);

	logic occupied;
	logic keep_own;
	logic take_new;

	assign occupied = CW'(IDX) < count;
	assign keep_own = occupied && (val_q >= cmd.value);
	// head cell has no left neighbor; otherwise the new value lands where left >= it
	assign take_new = (IDX == 0) || (left_val >= cmd.value);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (keep_own) begin
				val_q <= val_q;
			end else if (take_new) begin
				val_q <= cmd.value;
			end else begin
				val_q <= left_val;
			end
		end else if (cmd.rem) begin
			val_q <= right_val;
		end
	end

endmodule

// File: src/max_priority_queue.sv
// Max priority queue top level: a chain of sorted cells plus count and output register.
// Depends on mpq_pkg, mpq_req_if, mpq_rsp_if and mpq_cell.
//
// Usage:
//  - req carries one operation item: kind (insert / remove largest) and a
//    signed 32-bit value. rsp returns exactly one result item per request:
//    result_value, status (ok, overflow, underflow) and occupancy after the op.
//  - The store is a chain of DEPTH cells kept sorted, largest value in cell 0.
//    Insert: every cell compares the new value with its own and its left
//    neighbor in the same cycle and either keeps, takes the new value, or
//    takes the left neighbor's value (the tail shifts right by one).
//    Remove: cell 0 is the result and every cell takes its right neighbor.
//    Equal values are indistinguishable, so ties need no age tracking.
//  - Latency: a result is valid the cycle after the request is accepted.
//  - Throughput: one item per cycle while the receiver takes results,
//    independent of DEPTH; each cell does one compare pair per cycle.
//  - req.ready is high whenever the output register is empty or being taken,
//    so a stalled receiver holds the result and blocks new requests.
//  - Reset clears the count and the output valid; cell contents stay
//    undefined and are only read below the count.
//  - Occupancy carries the low five bits of the count.
module max_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	mpq_req_if.sink   req,
	mpq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic               accept;
	logic               ins_ok;
	logic               rem_ok;
	logic               full;
	logic               empty;
	mpq_pkg::cell_cmd_t cmd;
	mpq_pkg::value_t    cell_val [DEPTH];

	logic                                rsp_valid_q;
	mpq_pkg::value_t                     rsp_value_q;
	logic [mpq_pkg::StatusW-1:0]         rsp_status_q;
	logic [mpq_pkg::OccW-1:0]            rsp_occ_q;

	// output register frees up when empty or taken this cycle
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign ins_ok = accept && (req.kind == mpq_pkg::OP_INSERT) && !full;
	assign rem_ok = accept && (req.kind == mpq_pkg::OP_REMOVE) && !empty;

	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CW'(1);
		end else if (rem_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	assign cmd.ins   = ins_ok;
	assign cmd.rem   = rem_ok;
	assign cmd.value = req.value;

	// cell chain; the ends see their own value as the missing neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mpq_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.count    (count_q),
			.left_val ((i == 0) ? cell_val[i] : cell_val[(i == 0) ? 0 : i - 1]),
			.right_val((i == DEPTH - 1) ? cell_val[i] : cell_val[(i == DEPTH - 1) ? i : i + 1]),
			.val_q    (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_value_q <= rem_ok ? cell_val[0] : '0;
			rsp_occ_q   <= mpq_pkg::OccW'(count_d);
			if (req.kind == mpq_pkg::OP_INSERT) begin
				rsp_status_q <= full ? mpq_pkg::ST_OVERFLOW : mpq_pkg::ST_OK;
			end else begin
				rsp_status_q <= empty ? mpq_pkg::ST_UNDERFLOW : mpq_pkg::ST_OK;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_value_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.occupancy    = rsp_occ_q;

endmodule

// File: src/mpq_checker.sv
// Port-level checks for max_priority_queue, bound to the top level.
// Depends on mpq_pkg.
module mpq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input mpq_pkg::value_t             rsp_result_value,
	input logic [mpq_pkg::StatusW-1:0] rsp_status
);

	// an accepted request shows its result on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result after accepted request");

	// failed operations return zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == mpq_pkg::ST_UNDERFLOW ||
			rsp_status == mpq_pkg::ST_OVERFLOW) |-> rsp_result_value == '0)
		else $error("nonzero result on failed operation");

	// a stalled result is held and blocks new requests
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready ##1 (rsp_valid && $stable(rsp_result_value)))
		else $error("stalled result not held");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == mpq_pkg::ST_OK || rsp_status == mpq_pkg::ST_OVERFLOW ||
			rsp_status == mpq_pkg::ST_UNDERFLOW))
		else $error("undefined status code");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_result_value(rsp.result_value),
	.rsp_status      (rsp.status)
);
